// ----- hdl/lst_pkg.sv -----
package lst_pkg;

    localparam logic [2:0] FUNC_ADD   = 3'd0;
    localparam logic [2:0] FUNC_FIND  = 3'd1;
    localparam logic [2:0] FUNC_MARK  = 3'd2;
    localparam logic [2:0] FUNC_RELOC = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;
    localparam logic [2:0] FUNC_CLEAR = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EXTERNAL  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;

    localparam logic [1:0] TYPE_DATA     = 2'd1;
    localparam logic [1:0] TYPE_EXTERNAL = 2'd2;

    localparam logic [19:0] VALUE_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] name_chunk;
        logic        chunk_last;
        logic [19:0] value;
        logic [1:0]  sym_type;
        logic [7:0]  read_index;
        logic [19:0] relocation_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  hit_index;
        logic [19:0] out_value;
        logic [1:0]  out_type;
        logic        out_is_entry;
        logic [63:0] out_name_chunk;
        logic        result_last;
        logic [7:0]  symbol_total;
    } rsp_t;

    typedef struct packed {
        logic [19:0] value;
        logic [1:0]  typ;
        logic        entry;
    } attr_t;

endpackage

// ----- hdl/label_symbol_table_top.sv -----
// Label symbol table.
// Request channel (req_valid/req_stall/req): a name arrives as 8-byte chunks;
// the item with chunk_last set runs the operation chosen by func. Items without
// chunk_last only collect chunks and are taken in one cycle each.
// Response channel (rsp_valid/rsp_stall/rsp): one item per operation, or one per
// stored name chunk for a successful read by index (result_last on the final one).
// Unknown func codes give no response.
// Flow after the final chunk: the key is first canonicalized chunk by chunk, then
//   add/find/mark: the stored names are scanned (one name memory read per
//   cycle while scanning), then the chunks of a new symbol are written;
//   relocate: every symbol is walked through the attribute memory;
//   read by index: the attributes are read, then each chunk in turn;
//   clear: the symbol count is reset.
// The block takes one operation at a time; req_stall is high until its last
// response sits in the output register. A stalled response holds the block.
// Reset empties the table and the name buffer; memories need no clearing.
module label_symbol_table_top #(
    parameter int TABLE_DEPTH = 128,
    parameter int NAME_CHUNKS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lst_pkg::rsp_t rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH * NAME_CHUNKS);
    localparam int JW = (NAME_CHUNKS > 1) ? $clog2(NAME_CHUNKS) : 1;
    localparam int PW = $clog2(NAME_CHUNKS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CANON, S_SCAN, S_ATTR_RD, S_ATTR, S_WR, S_RELOC, S_IRD, S_IDAT, S_EMIT
    } state_t;

    state_t            state_reg;
    logic [63:0]       key_reg [NAME_CHUNKS];
    logic [PW-1:0]     pos_reg;
    logic [JW-1:0]     cj_reg;
    logic              ended_reg;
    logic [CW-1:0]     count_reg;
    logic [2:0]        func_reg;
    logic [19:0]       val_reg;
    logic [1:0]        typ_reg;
    logic [7:0]        ridx_reg;
    logic [19:0]       off_reg;
    logic [CW-1:0]     si_reg;
    logic [JW-1:0]     sj_reg;
    logic [AW-1:0]     addr_reg;
    logic              pv_reg;
    logic [IW-1:0]     pi_reg;
    logic [JW-1:0]     pj_reg;
    logic              eq_reg;
    logic [IW-1:0]     idx_reg;
    lst_pkg::attr_t    hold_reg;
    lst_pkg::rsp_t     res_reg;
    logic              more_reg;
    lst_pkg::rsp_t     out_reg;
    logic              out_valid_reg;

    logic [63:0]       name_mem [TABLE_DEPTH * NAME_CHUNKS];
    lst_pkg::attr_t    attr_mem [TABLE_DEPTH];
    logic [63:0]       name_q;
    lst_pkg::attr_t    attr_q;

    logic              name_re, name_we, attr_re, attr_we;
    logic [AW-1:0]     name_raddr, name_waddr;
    logic [63:0]       name_wdata;
    logic [IW-1:0]     attr_raddr, attr_waddr;
    lst_pkg::attr_t    attr_wdata;

    logic [63:0]       canon_chunk;
    logic              canon_end;
    logic              issue;
    logic              name_eq;
    logic [20:0]       reloc_sum;
    logic [AW-1:0]     base_addr;

    function automatic lst_pkg::rsp_t make_res(
        input logic [2:0] st, input logic hit, input logic [IW-1:0] idx,
        input lst_pkg::attr_t a, input logic [63:0] chunk, input logic last,
        input logic [CW-1:0] total);
        lst_pkg::rsp_t r;
        r = '0;
        r.status         = st;
        r.out_name_chunk = chunk;
        r.result_last    = last;
        r.symbol_total   = 8'(total);
        if (hit)
        begin
            r.hit_index    = 7'(idx);
            r.out_value    = a.value;
            r.out_type     = a.typ;
            r.out_is_entry = a.entry;
        end
        return r;
    endfunction

    always_comb
    begin
        logic e;
        logic [7:0] b8;
        e = ended_reg;
        canon_chunk = key_reg[cj_reg];
        for (int b = 0; b < 8; b++)
        begin
            b8 = canon_chunk[8*b +: 8];
            if (e)
                canon_chunk[8*b +: 8] = 8'd0;
            else if (b8 == 8'd0)
                e = 1'b1;
        end
        canon_end = e;
    end

    assign issue     = (si_reg < count_reg);
    assign name_eq   = (name_q == key_reg[pj_reg]);
    assign reloc_sum = {1'b0, attr_q.value} + {1'b0, off_reg};
    assign base_addr = AW'(32'(ridx_reg) * NAME_CHUNKS);

    always_comb
    begin
        name_re    = 1'b0;
        name_raddr = addr_reg;
        name_we    = 1'b0;
        name_waddr = addr_reg;
        name_wdata = key_reg[sj_reg];
        attr_re    = 1'b0;
        attr_raddr = idx_reg;
        attr_we    = 1'b0;
        attr_waddr = idx_reg;
        attr_wdata = attr_q;
        unique case (state_reg)
            S_SCAN:
            begin
                name_re = issue;
            end
            S_ATTR_RD:
            begin
                attr_re = 1'b1;
            end
            S_ATTR:
            begin
                if (func_reg == lst_pkg::FUNC_MARK && attr_q.typ != lst_pkg::TYPE_EXTERNAL)
                begin
                    attr_we          = 1'b1;
                    attr_wdata.entry = 1'b1;
                end
            end
            S_WR:
            begin
                name_we = 1'b1;
                if (sj_reg == JW'(NAME_CHUNKS - 1))
                begin
                    attr_we    = 1'b1;
                    attr_waddr = count_reg[IW-1:0];
                    attr_wdata = '{value: val_reg, typ: typ_reg, entry: 1'b0};
                end
            end
            S_RELOC:
            begin
                attr_re    = issue;
                attr_raddr = si_reg[IW-1:0];
                attr_waddr = pi_reg;
                if (pv_reg && attr_q.typ == lst_pkg::TYPE_DATA)
                begin
                    attr_we          = 1'b1;
                    attr_wdata.value = reloc_sum[20] ? lst_pkg::VALUE_MAX : reloc_sum[19:0];
                end
            end
            S_IRD:
            begin
                name_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[name_waddr] <= name_wdata;
        if (name_re)
            name_q <= name_mem[name_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
            attr_mem[attr_waddr] <= attr_wdata;
        if (attr_re)
            attr_q <= attr_mem[attr_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int c = 0; c < NAME_CHUNKS; c++)
                key_reg[c] <= '0;
            pos_reg       <= '0;
            cj_reg        <= '0;
            ended_reg     <= 1'b0;
            count_reg     <= '0;
            pv_reg        <= 1'b0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!rsp_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (pos_reg < PW'(NAME_CHUNKS))
                        begin
                            key_reg[JW'(pos_reg)] <= req.name_chunk;
                            pos_reg <= pos_reg + 1'b1;
                        end
                        if (req.chunk_last)
                        begin
                            func_reg  <= req.func;
                            val_reg   <= req.value;
                            typ_reg   <= req.sym_type;
                            ridx_reg  <= req.read_index;
                            off_reg   <= req.relocation_offset;
                            cj_reg    <= '0;
                            ended_reg <= 1'b0;
                            state_reg <= S_CANON;
                        end
                    end
                end
                S_CANON:
                begin
                    key_reg[cj_reg] <= canon_chunk;
                    ended_reg       <= canon_end;
                    cj_reg          <= cj_reg + 1'b1;
                    if (cj_reg == JW'(NAME_CHUNKS - 1))
                    begin
                        si_reg   <= '0;
                        sj_reg   <= '0;
                        addr_reg <= '0;
                        pv_reg   <= 1'b0;
                        more_reg <= 1'b0;
                        case (func_reg)
                            lst_pkg::FUNC_ADD, lst_pkg::FUNC_FIND, lst_pkg::FUNC_MARK:
                                state_reg <= S_SCAN;
                            lst_pkg::FUNC_RELOC:
                                state_reg <= S_RELOC;
                            lst_pkg::FUNC_READ:
                            begin
                                if (32'(ridx_reg) >= 32'(count_reg))
                                begin
                                    res_reg   <= make_res(lst_pkg::ST_BAD_INDEX, 1'b0, '0,
                                                          '0, '0, 1'b1, count_reg);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    idx_reg   <= IW'(ridx_reg);
                                    addr_reg  <= base_addr;
                                    state_reg <= S_ATTR_RD;
                                end
                            end
                            lst_pkg::FUNC_CLEAR:
                            begin
                                count_reg <= '0;
                                res_reg   <= make_res(lst_pkg::ST_OK, 1'b0, '0, '0, '0,
                                                      1'b1, '0);
                                state_reg <= S_EMIT;
                            end
                            default:
                            begin
                                for (int c = 0; c < NAME_CHUNKS; c++)
                                    key_reg[c] <= '0;
                                pos_reg   <= '0;
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    pv_reg <= issue;
                    pi_reg <= si_reg[IW-1:0];
                    pj_reg <= sj_reg;
                    if (issue)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                        if (sj_reg == JW'(NAME_CHUNKS - 1))
                        begin
                            sj_reg <= '0;
                            si_reg <= si_reg + 1'b1;
                        end
                        else
                            sj_reg <= sj_reg + 1'b1;
                    end
                    if (pv_reg)
                    begin
                        eq_reg <= ((pj_reg == '0) || eq_reg) && name_eq;
                        if (pj_reg == JW'(NAME_CHUNKS - 1) && ((pj_reg == '0) || eq_reg)
                            && name_eq)
                        begin
                            idx_reg   <= pi_reg;
                            state_reg <= S_ATTR_RD;
                        end
                    end
                    else if (!issue)
                    begin
                        if (func_reg != lst_pkg::FUNC_ADD)
                        begin
                            res_reg   <= make_res(lst_pkg::ST_NOT_FOUND, 1'b0, '0, '0, '0,
                                                  1'b1, count_reg);
                            state_reg <= S_EMIT;
                        end
                        else if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            res_reg   <= make_res(lst_pkg::ST_FULL, 1'b0, '0, '0, '0,
                                                  1'b1, count_reg);
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            addr_reg  <= AW'(32'(count_reg) * NAME_CHUNKS);
                            sj_reg    <= '0;
                            state_reg <= S_WR;
                        end
                    end
                end
                S_WR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    sj_reg   <= sj_reg + 1'b1;
                    if (sj_reg == JW'(NAME_CHUNKS - 1))
                    begin
                        count_reg <= count_reg + 1'b1;
                        res_reg   <= make_res(lst_pkg::ST_OK, 1'b1, count_reg[IW-1:0],
                                              '{value: val_reg, typ: typ_reg, entry: 1'b0},
                                              '0, 1'b1, count_reg + 1'b1);
                        state_reg <= S_EMIT;
                    end
                end
                S_ATTR_RD:
                begin
                    state_reg <= S_ATTR;
                end
                S_ATTR:
                begin
                    state_reg <= S_EMIT;
                    case (func_reg)
                        lst_pkg::FUNC_ADD:
                            res_reg <= make_res(lst_pkg::ST_DUP, 1'b1, idx_reg, attr_q, '0,
                                                1'b1, count_reg);
                        lst_pkg::FUNC_MARK:
                        begin
                            if (attr_q.typ == lst_pkg::TYPE_EXTERNAL)
                                res_reg <= make_res(lst_pkg::ST_EXTERNAL, 1'b1, idx_reg,
                                                    attr_q, '0, 1'b1, count_reg);
                            else
                                res_reg <= make_res(lst_pkg::ST_OK, 1'b1, idx_reg,
                                                    attr_wdata, '0, 1'b1, count_reg);
                        end
                        lst_pkg::FUNC_READ:
                        begin
                            hold_reg  <= attr_q;
                            sj_reg    <= '0;
                            state_reg <= S_IRD;
                        end
                        default:
                            res_reg <= make_res(lst_pkg::ST_OK, 1'b1, idx_reg, attr_q, '0,
                                                1'b1, count_reg);
                    endcase
                end
                S_RELOC:
                begin
                    pv_reg <= issue;
                    pi_reg <= si_reg[IW-1:0];
                    if (issue)
                        si_reg <= si_reg + 1'b1;
                    else if (!pv_reg)
                    begin
                        res_reg   <= make_res(lst_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1,
                                              count_reg);
                        state_reg <= S_EMIT;
                    end
                end
                S_IRD:
                begin
                    state_reg <= S_IDAT;
                end
                S_IDAT:
                begin
                    res_reg   <= make_res(lst_pkg::ST_OK, 1'b1, idx_reg, hold_reg, name_q,
                                          sj_reg == JW'(NAME_CHUNKS - 1), count_reg);
                    more_reg  <= (sj_reg != JW'(NAME_CHUNKS - 1));
                    addr_reg  <= addr_reg + 1'b1;
                    sj_reg    <= sj_reg + 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !rsp_stall)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        if (more_reg)
                            state_reg <= S_IRD;
                        else
                        begin
                            for (int c = 0; c < NAME_CHUNKS; c++)
                                key_reg[c] <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("symbol count beyond table depth");
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && res_reg.status == lst_pkg::ST_FULL)
        |-> count_reg == CW'(TABLE_DEPTH))
        else $error("full reported with room left");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_RELOC) |-> si_reg <= count_reg)
        else $error("scan ran past the symbol count");
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && sj_reg == JW'(NAME_CHUNKS - 1))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not grow the table");
`endif

endmodule
